[rtl/ahe_pkg.sv]
// Package for the ack run header encoder: shared types and constants.
// No dependencies; imported by ahe_run_unit and ack_run_header_encoder_core.
package ahe_pkg;

    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 8;
    localparam int SEQ_W        = 9;
    localparam int ACK_W        = 5;
    localparam int TYPE_W       = 5;
    localparam int LEN_W        = 3;
    localparam int START_W      = 5;
    localparam logic [LEN_W-1:0] RUN_MAX_LEN = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR0,
        ST_HDR1,
        ST_SCAN,
        ST_TERM
    } ahe_state_t;

    typedef struct packed {
        logic               clear;
        logic               step;
        logic               slot_bit;
        logic [START_W-1:0] slot_idx;
    } ahe_run_ctl_t;

    typedef struct packed {
        logic                          emit;
        logic                          pending;
        logic [OUT_DATA_W-1:0]         run_byte;
    } ahe_run_sts_t;

endpackage

[rtl/ahe_run_unit.sv]
// Run tracker: takes one slot bit per step, keeps the open run's start and
// length, and flags when a (start, length) run byte is due. Uses ahe_pkg.
module ahe_run_unit
    import ahe_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ahe_run_ctl_t ctl,
    output ahe_run_sts_t sts
);

    logic [LEN_W-1:0]   len_reg, len_next;
    logic [START_W-1:0] start_reg, start_next;
    logic               len_full;

    assign len_full         = (len_reg == RUN_MAX_LEN);
    assign sts.pending      = (len_reg != '0);
    assign sts.emit         = sts.pending && (!ctl.slot_bit || len_full);
    assign sts.run_byte     = {start_reg, len_reg};

    always_comb begin
        len_next   = len_reg;
        start_next = start_reg;
        if (ctl.clear) begin
            len_next = '0;
        end else if (ctl.step) begin
            if (ctl.slot_bit) begin
                if (len_reg == '0 || len_full) begin
                    start_next = ctl.slot_idx;
                    len_next   = LEN_W'(1);
                end else begin
                    len_next = len_reg + LEN_W'(1);
                end
            end else begin
                len_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
        start_reg <= start_next;
    end

endmodule

[rtl/ack_run_header_encoder_core.sv]
// Ack run header encoder top: sequencer, slot scan and output register.
// After accept, the sequencer moves to the first header state, which loads
// the first byte into the output register. New requests are taken only in
// idle; the run tracker steps over one slot each cycle unless a due run byte
// waits on a stalled output. Synchronous active-low reset empties the output
// and returns to idle. Depends on ahe_pkg and ahe_run_unit.
module ack_run_header_encoder_core
    import ahe_pkg::*;
#(
    parameter int WINDOW_SLOTS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] slot_mask, [40:32] sequence_number, [41] parity_bit,
    // [46:42] acked_mod32, [51:47] type_flags, [55:52] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] header_byte
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);

    ahe_state_t                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [WINDOW_SLOTS-1:0]     mask_reg, mask_next;
    logic [SEQ_W-1:0]            seq_reg;
    logic                        par_reg;
    logic [ACK_W-1:0]            ack_reg;
    logic [TYPE_W-1:0]           type_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]       out_byte_reg;
    logic                        out_last_reg;
    logic                        out_free, load_en, load_last, accept, at_end;
    logic [OUT_DATA_W-1:0]       load_byte;
    ahe_run_ctl_t                run_ctl;
    ahe_run_sts_t                run_sts;

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign at_end   = (cnt_reg == CNT_W'(WINDOW_SLOTS));

    ahe_run_unit u_run (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (run_ctl),
        .sts     (run_sts)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        cnt_reg  <= cnt_next;
        mask_reg <= mask_next;
        if (accept) begin
            seq_reg  <= s_tdata[40:32];
            par_reg  <= s_tdata[41];
            ack_reg  <= s_tdata[46:42];
            type_reg <= s_tdata[51:47];
        end
        if (load_en) begin
            out_byte_reg <= load_byte;
            out_last_reg <= load_last;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        mask_next        = mask_reg;
        s_tready         = 1'b0;
        load_en          = 1'b0;
        load_byte        = '0;
        load_last        = 1'b0;
        run_ctl.clear    = 1'b0;
        run_ctl.step     = 1'b0;
        run_ctl.slot_bit = mask_reg[0];
        run_ctl.slot_idx = START_W'(cnt_reg);
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mask_next  = s_tdata[WINDOW_SLOTS-1:0];
                    state_next = ST_HDR0;
                end
            end
            ST_HDR0: begin
                if (out_free) begin
                    load_en    = 1'b1;
                    load_byte  = {seq_reg[5:0], par_reg, 1'b1};
                    state_next = ST_HDR1;
                end
            end
            ST_HDR1: begin
                run_ctl.clear = 1'b1;
                if (out_free) begin
                    load_en    = 1'b1;
                    load_byte  = {ack_reg, seq_reg[8:6]};
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (at_end) begin
                    if (run_sts.pending) begin
                        if (out_free) begin
                            load_en       = 1'b1;
                            load_byte     = run_sts.run_byte;
                            run_ctl.clear = 1'b1;
                        end
                    end else begin
                        state_next = ST_TERM;
                    end
                end else if (!run_sts.emit || out_free) begin
                    run_ctl.step = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    mask_next    = mask_reg >> 1;
                    if (run_sts.emit) begin
                        load_en   = 1'b1;
                        load_byte = run_sts.run_byte;
                    end
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    load_en    = 1'b1;
                    load_byte  = {type_reg, LEN_W'(0)};
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load_en || (out_valid_reg && !m_tready);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input taken while a header is in progress");

    a_last_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (state_reg != ST_SCAN && state_reg != ST_TERM))
        else $error("terminator shown before the scan finished");

    a_last_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] == 3'd0))
        else $error("terminator carries a nonzero run length");

endmodule

[dv/ack_run_header_encoder_checker.sv]
// Checker for the ack run header encoder: predicts the header bytes of each
// accepted request and compares them, in order, with the bytes on the output.
// Depends on ahe_pkg; instantiated by ack_run_header_encoder_core_tb.
module ack_run_header_encoder_checker
    import ahe_pkg::*;
#(
    parameter int WINDOW_SLOTS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    output int                    error_count,
    output int                    bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_DATA_W-1:0] hdr;
        logic                  fin;
    } hdr_byte_t;

    hdr_byte_t header_q[$];

    initial error_count = 0;
    assign bytes_pending = header_q.size();

    function automatic void push_byte(input logic [OUT_DATA_W-1:0] b, input logic fin);
        hdr_byte_t e;
        e.hdr = b;
        e.fin = fin;
        header_q.insert(header_q.size(), e);
    endfunction

    function automatic void predict_header(input logic [IN_DATA_W-1:0] req);
        logic [31:0]        mask;
        logic [SEQ_W-1:0]   seq;
        logic               par;
        logic [ACK_W-1:0]   acked;
        logic [TYPE_W-1:0]  flags;
        int                 i;
        int                 j;
        int                 start;
        int                 rem;
        int                 take;
        logic [START_W-1:0] start_f;
        logic [LEN_W-1:0]   len_f;
        mask  = req[31:0];
        seq   = req[40:32];
        par   = req[41];
        acked = req[46:42];
        flags = req[51:47];

        push_byte({seq[5:0], par, 1'b1}, 1'b0);
        push_byte({acked, seq[8:6]}, 1'b0);

        i = 0;
        while (i < WINDOW_SLOTS) begin
            if (!mask[i]) begin
                i++;
            end else begin
                j = i;
                while (j < WINDOW_SLOTS && mask[j])
                    j++;
                start = i;
                rem   = j - i;
                while (rem > 0) begin
                    take    = (rem > int'(RUN_MAX_LEN)) ? int'(RUN_MAX_LEN) : rem;
                    start_f = start[START_W-1:0];
                    len_f   = take[LEN_W-1:0];
                    push_byte({start_f, len_f}, 1'b0);
                    start += take;
                    rem   -= take;
                end
                i = j;
            end
        end

        push_byte({flags, 3'b000}, 1'b1);
    endfunction

    always @(posedge aclk) begin
        hdr_byte_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_header(s_tdata);
            if (m_tvalid && m_tready) begin
                if (header_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected item: expected none, actual byte=%02h last=%0b",
                             $time, m_tdata, m_tlast);
                end else begin
                    e = header_q.pop_front();
                    if (m_tdata !== e.hdr || m_tlast !== e.fin) begin
                        error_count++;
                        $display("%0t: expected byte=%02h last=%0b, actual byte=%02h last=%0b",
                                 $time, e.hdr, e.fin, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

endmodule

[dv/ack_run_header_encoder_core_tb.sv]
// Testbench top for ack_run_header_encoder_core: drives header requests with
// directed and random slot masks under several idle/stall phases.
// Depends on ahe_pkg, the core RTL and ack_run_header_encoder_checker.
module ack_run_header_encoder_core_tb;
    import ahe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 32;
    localparam int RAND_ITEMS  = 250;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 60;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int error_count;
    int bytes_pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    ack_run_header_encoder_core #(
        .WINDOW_SLOTS(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    ack_run_header_encoder_checker #(
        .WINDOW_SLOTS(SLOTS)
    ) header_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .error_count  (error_count),
        .bytes_pending(bytes_pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ack_run_header_encoder_core: mismatch");
            $finish;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_req(input logic [31:0] mask,
                                                     input logic [SEQ_W-1:0] seq,
                                                     input logic par,
                                                     input logic [ACK_W-1:0] acked,
                                                     input logic [TYPE_W-1:0] flags);
        return {4'b0000, flags, acked, par, seq, mask};
    endfunction

    function automatic logic [IN_DATA_W-1:0] req_with_mask(input logic [31:0] mask);
        return pack_req(mask, SEQ_W'($urandom()), 1'($urandom()), ACK_W'($urandom()),
                        TYPE_W'($urandom()));
    endfunction

    // Mask shapes: uniform, sparse, dense, alternating runs, single run
    function automatic logic [31:0] rand_mask();
        logic [31:0] m;
        int          p;
        int          len;
        int          lo;
        logic        v;
        m = '0;
        case ($urandom_range(0, 4))
            0: begin
                m = $urandom();
            end
            1: begin
                m = $urandom() & $urandom() & $urandom();
            end
            2: begin
                m = $urandom() | $urandom() | $urandom();
            end
            3: begin
                p = 0;
                v = 1'($urandom_range(0, 1));
                while (p < 32) begin
                    len = $urandom_range(1, 16);
                    while (len > 0 && p < 32) begin
                        m[p] = v;
                        p++;
                        len--;
                    end
                    v = ~v;
                end
            end
            default: begin
                lo  = $urandom_range(0, 31);
                len = $urandom_range(1, 32 - lo);
                for (p = lo; p < lo + len; p++)
                    m[p] = 1'b1;
            end
        endcase
        return m;
    endfunction

    task automatic send_item(input logic [IN_DATA_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++)
            send_item(req_with_mask(rand_mask()));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(pack_req(32'h0000_0000, 9'd0,   1'b0, 5'd0,  5'd0));
        send_item(pack_req(32'hFFFF_FFFF, 9'd511, 1'b1, 5'd31, 5'd31));
        send_item(pack_req(32'h5555_5555, 9'h155, 1'b0, 5'd10, 5'd5));
        send_item(pack_req(32'hAAAA_AAAA, 9'h0AA, 1'b1, 5'd21, 5'd26));
        send_item(pack_req(32'h8000_0000, 9'd64,  1'b0, 5'd1,  5'd16));
        send_item(pack_req(32'h0000_0001, 9'd63,  1'b1, 5'd30, 5'd1));
        send_item(pack_req(32'h8000_0001, 9'd448, 1'b0, 5'd16, 5'd15));
        send_item(req_with_mask(32'h0000_007F));
        send_item(req_with_mask(32'h0000_00FF));
        send_item(req_with_mask(32'h0000_3FFF));
        send_item(req_with_mask(32'h0000_7FFF));
        send_item(req_with_mask(32'hFE00_0000));
        send_item(req_with_mask(32'hFFFF_FFFE));
        send_item(req_with_mask(32'h7FFF_FFFF));
        send_item(req_with_mask(32'h0F0F_0F0F));
        send_item(req_with_mask(32'hF0F0_F0F0));
        send_item(req_with_mask(32'h0001_FFFE));
        send_item(req_with_mask(32'hC000_0003));

        send_random(RAND_ITEMS / 4);

        send_idle_pct  = 87;
        recv_stall_pct = 0;
        send_random(RAND_ITEMS / 4);

        send_idle_pct  = 0;
        recv_stall_pct = 87;
        send_random(RAND_ITEMS / 4);

        send_idle_pct  = 10;
        recv_stall_pct = 10;
        send_random(RAND_ITEMS / 4);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bytes_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0 && bytes_pending == 0) begin
            $display("ack_run_header_encoder_core: match");
        end else begin
            $display("ack_run_header_encoder_core: mismatch");
        end
        $finish;
    end

endmodule
